// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSG_CHECK_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSG_CHECK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/ssg_pkg.sv
// ----------------------------------------------------------------------------
// Slope segment generator package
// Shared types and constants of the segment pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssg_pkg;

  localparam int SLOPE_W = 24;
  localparam logic [24:0] SLOPE_MAX = 25'd8388607;
  localparam int RAD_W = 47;
  localparam int ROOT_W = 24;
  localparam int H_W = 15;
  localparam int PIX_W = 12;
  localparam int PIX_MAX = 2047;

  typedef enum logic [0:0] {
    CFG_X_EXTENT = 1'b0,
    CFG_Y_EXTENT = 1'b1
  } ssg_cfg_idx_t;

  typedef enum logic [2:0] {
    BAND_RED        = 3'd0,
    BAND_ORANGE     = 3'd1,
    BAND_YELLOW     = 3'd2,
    BAND_GREEN      = 3'd3,
    BAND_LIGHT_BLUE = 3'd4,
    BAND_NAVY       = 3'd5
  } ssg_band_t;

  // Per-item data that travels alongside the arithmetic.
  typedef struct packed {
    logic signed [7:0]         gx;
    logic signed [7:0]         gy;
    ssg_band_t                 band;
    logic                      nz;
    logic signed [SLOPE_W-1:0] slope;
  } ssg_side_t;

endpackage

`default_nettype wire

// File: sv/slope_segment_generator_unit.sv
// ----------------------------------------------------------------------------
// Slope segment generator
// Turns grid points of the field dy/dx = -y/x into short screen segments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with in_grid_x and in_grid_y. An item
//   is taken at a clock edge where in_valid is high and in_stall is low.
//   Result channel: out_valid / out_stall with one result per input item:
//   segment flag, start and end pixels, color band. A result is taken at an
//   edge where out_valid is high and out_stall is low.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data. Index 0
//   sets the x extent, index 1 the y extent; write them only while idle.
//   cfg_ready is always high.
//   Items pass through the slope stage, the square root, the half-width divider
//   and the screen mapping. One item per cycle is accepted while in_stall is
//   low; every stage holds a valid bit.
//   When the receiver stalls, stages fill up behind the output register and
//   in_stall rises only once every stage holds an item; nothing is lost.
//   Reset empties the pipeline and sets both extents to 10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slope_segment_generator_unit #(
  parameter int HALF_SCREEN_WIDTH  = 159,
  parameter int HALF_SCREEN_HEIGHT = 119
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [7:0]             in_grid_x,
  input  wire logic signed [7:0]             in_grid_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_segment_valid,
  output logic signed [ssg_pkg::PIX_W-1:0]   out_start_x,
  output logic signed [ssg_pkg::PIX_W-1:0]   out_start_y,
  output logic signed [ssg_pkg::PIX_W-1:0]   out_end_x,
  output logic signed [ssg_pkg::PIX_W-1:0]   out_end_y,
  output logic [2:0]                         out_color_band,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [6:0]                    cfg_data
);

  logic [6:0] x_ext_r;
  logic [6:0] y_ext_r;
  logic [6:0] x_ext_nxt;
  logic [6:0] y_ext_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    x_ext_nxt = x_ext_r;
    y_ext_nxt = y_ext_r;
    if (cfg_valid && cfg_ready) begin
      case (ssg_pkg::ssg_cfg_idx_t'(cfg_index))
        ssg_pkg::CFG_X_EXTENT: x_ext_nxt = cfg_data;
        ssg_pkg::CFG_Y_EXTENT: y_ext_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_ext_r <= 7'd10;
      y_ext_r <= 7'd10;
    end else begin
      x_ext_r <= x_ext_nxt;
      y_ext_r <= y_ext_nxt;
    end
  end

  logic                              sl_valid;
  logic                              sl_stall;
  ssg_pkg::ssg_side_t                sl_side;
  logic [ssg_pkg::RAD_W-1:0]         sl_rad;
  logic                              sq_valid;
  logic                              sq_stall;
  ssg_pkg::ssg_side_t                sq_side;
  logic [ssg_pkg::ROOT_W-1:0]        sq_root;
  logic                              rc_valid;
  logic                              rc_stall;
  ssg_pkg::ssg_side_t                rc_side;
  logic [ssg_pkg::H_W-1:0]           rc_h;

  ssg_slope u_slope (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_gx    (in_grid_x),
    .up_gy    (in_grid_y),
    .dn_valid (sl_valid),
    .dn_stall (sl_stall),
    .dn_side  (sl_side),
    .dn_rad   (sl_rad)
  );

  ssg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sl_valid),
    .up_stall (sl_stall),
    .up_side  (sl_side),
    .up_rad   (sl_rad),
    .dn_valid (sq_valid),
    .dn_stall (sq_stall),
    .dn_side  (sq_side),
    .dn_root  (sq_root)
  );

  ssg_recip u_recip (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sq_valid),
    .up_stall (sq_stall),
    .up_side  (sq_side),
    .up_root  (sq_root),
    .dn_valid (rc_valid),
    .dn_stall (rc_stall),
    .dn_side  (rc_side),
    .dn_h     (rc_h)
  );

  ssg_map #(
    .HALF_SCREEN_WIDTH  (HALF_SCREEN_WIDTH),
    .HALF_SCREEN_HEIGHT (HALF_SCREEN_HEIGHT)
  ) u_map (
    .clk              (clk),
    .rst_n            (rst_n),
    .up_valid         (rc_valid),
    .up_stall         (rc_stall),
    .up_side          (rc_side),
    .up_h             (rc_h),
    .x_ext            (x_ext_r),
    .y_ext            (y_ext_r),
    .dn_valid         (out_valid),
    .dn_stall         (out_stall),
    .dn_segment_valid (out_segment_valid),
    .dn_start_x       (out_start_x),
    .dn_start_y       (out_start_y),
    .dn_end_x         (out_end_x),
    .dn_end_y         (out_end_y),
    .dn_color_band    (out_color_band)
  );

  // Back-pressure can only come from a stalled result at the output.
  `SSG_CHECK_IMPLIES(a_stall_source, in_stall, out_valid && out_stall)
  // Items with no segment carry all-zero fields.
  `SSG_CHECK_IMPLIES(a_blank_result, out_valid && !out_segment_valid, out_start_x == 12'h000 && out_start_y == 12'h000 && out_end_x == 12'h000 && out_end_y == 12'h000 && out_color_band == 3'd0)
  // Pixels saturate symmetrically, so the most negative code never appears.
  `SSG_CHECK_IMPLIES(a_pix_sat, out_valid, out_start_x != 12'h800 && out_start_y != 12'h800 && out_end_x != 12'h800 && out_end_y != 12'h800)
  // A stalled result stays valid, with start x and end y unchanged, for the next cycle.
  `SSG_CHECK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_start_x) && $stable(out_end_y))

endmodule

`default_nettype wire

// File: sv/ssg_slope.sv
// ----------------------------------------------------------------------------
// Slope stage
// Computes the Q8.16 slope -y/x by a reciprocal table, the color band and
// the square-root radicand 2^32 + slope^2, over three register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_slope (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         up_valid,
  output logic                              up_stall,
  input  wire logic signed [7:0]            up_gx,
  input  wire logic signed [7:0]            up_gy,
  output logic                              dn_valid,
  input  wire logic                         dn_stall,
  output ssg_pkg::ssg_side_t                dn_side,
  output logic [ssg_pkg::RAD_W-1:0]         dn_rad
);

  localparam int N = 3;

  logic [N-1:0] v_r;
  logic [N-1:0] hold;
  logic [N-1:0] en;
  logic [N-1:0] vin;

  // ceil(2^30 / (i + 1)), so that a * 2^16 / b comes out exact after >> 14.
  logic [30:0] recip_tab [0:127];

  for (genvar g = 0; g < 128; g++) begin : g_recip
    localparam logic [30:0] RV = 31'((2 ** 30 + g) / (g + 1));
    assign recip_tab[g] = RV;
  end

  for (genvar k = 0; k < N; k++) begin : g_flow
    if (k == N - 1) begin : g_last
      assign hold[k] = dn_stall;
    end else begin : g_mid
      assign hold[k] = v_r[k+1] & hold[k+1];
    end
    assign en[k] = ~v_r[k] | ~hold[k];
  end

  assign vin = {v_r[N-2:0], up_valid};
  assign up_stall = v_r[0] & hold[0];
  assign dn_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  // Stage 0: magnitudes, reciprocal lookup and band.
  logic [7:0]         abs_gx;
  logic [7:0]         abs_gy;
  logic [6:0]         recip_idx;
  logic signed [9:0]  n10;
  logic signed [9:0]  dn10;
  logic signed [9:0]  dn2;
  ssg_pkg::ssg_side_t side0_nxt;
  logic [7:0]         a_r;
  logic [30:0]        m_r;
  logic               neg_r;
  ssg_pkg::ssg_side_t side0_r;

  always_comb begin
    abs_gx = up_gx[7] ? 8'(-up_gx) : 8'(up_gx);
    abs_gy = up_gy[7] ? 8'(-up_gy) : 8'(up_gy);
    recip_idx = 7'(abs_gx - 8'd1);
    // Slope sign is folded into the numerator so the denominator is positive.
    n10 = up_gx[7] ? 10'(up_gy) : -10'(up_gy);
    dn10 = up_gx[7] ? -10'(up_gx) : 10'(up_gx);
    dn2 = dn10 <<< 1;
    side0_nxt = '0;
    side0_nxt.gx = up_gx;
    side0_nxt.gy = up_gy;
    side0_nxt.nz = (up_gx != 8'sd0);
    if (n10 >= dn2) begin
      side0_nxt.band = ssg_pkg::BAND_RED;
    end else if (n10 >= dn10) begin
      side0_nxt.band = ssg_pkg::BAND_ORANGE;
    end else if (n10 >= 10'sd0) begin
      side0_nxt.band = ssg_pkg::BAND_YELLOW;
    end else if (n10 >= -dn10) begin
      side0_nxt.band = ssg_pkg::BAND_GREEN;
    end else if (n10 >= -dn2) begin
      side0_nxt.band = ssg_pkg::BAND_LIGHT_BLUE;
    end else begin
      side0_nxt.band = ssg_pkg::BAND_NAVY;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= abs_gy;
      m_r <= recip_tab[recip_idx];
      neg_r <= (up_gy[7] == up_gx[7]);
      side0_r <= side0_nxt;
    end
  end

  // Stage 1: quotient by reciprocal multiply, sign and saturation.
  logic [38:0]        quo_prod;
  logic [24:0]        quo;
  ssg_pkg::ssg_side_t side1_nxt;
  ssg_pkg::ssg_side_t side1_r;

  always_comb begin
    quo_prod = 39'(a_r) * 39'(m_r);
    quo = quo_prod[38:14];
    side1_nxt = side0_r;
    if (neg_r) begin
      side1_nxt.slope = ssg_pkg::SLOPE_W'(-quo);
    end else if (quo > ssg_pkg::SLOPE_MAX) begin
      side1_nxt.slope = ssg_pkg::SLOPE_W'(ssg_pkg::SLOPE_MAX);
    end else begin
      side1_nxt.slope = ssg_pkg::SLOPE_W'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side1_r <= side1_nxt;
    end
  end

  // Stage 2: radicand 1 + slope^2 in Q.32.
  logic signed [47:0]        sq;
  logic [ssg_pkg::RAD_W-1:0] rad_nxt;
  logic [ssg_pkg::RAD_W-1:0] rad_r;
  ssg_pkg::ssg_side_t        side2_r;

  always_comb begin
    sq = 48'(side1_r.slope) * 48'(side1_r.slope);
    rad_nxt = ssg_pkg::RAD_W'(sq) + {14'b0, 1'b1, 32'b0};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rad_r <= rad_nxt;
      side2_r <= side1_r;
    end
  end

  assign dn_side = side2_r;
  assign dn_rad = rad_r;

endmodule

`default_nettype wire

// File: sv/ssg_sqrt.sv
// ----------------------------------------------------------------------------
// Square root pipeline
// Bit-by-bit integer square root of the radicand, four result bits per stage
// over six register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_stall,
  input  wire ssg_pkg::ssg_side_t            up_side,
  input  wire logic [ssg_pkg::RAD_W-1:0]     up_rad,
  output logic                               dn_valid,
  input  wire logic                          dn_stall,
  output ssg_pkg::ssg_side_t                 dn_side,
  output logic [ssg_pkg::ROOT_W-1:0]         dn_root
);

  localparam int N = 6;
  localparam int STEPS = 4;

  logic [N-1:0] v_r;
  logic [N-1:0] hold;
  logic [N-1:0] en;
  logic [N-1:0] vin;

  for (genvar k = 0; k < N; k++) begin : g_flow
    if (k == N - 1) begin : g_last
      assign hold[k] = dn_stall;
    end else begin : g_mid
      assign hold[k] = v_r[k+1] & hold[k+1];
    end
    assign en[k] = ~v_r[k] | ~hold[k];
  end

  assign vin = {v_r[N-2:0], up_valid};
  assign up_stall = v_r[0] & hold[0];
  assign dn_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  logic [47:0]                 rad_r    [0:N-1];
  logic [26:0]                 rem_r    [0:N-1];
  logic [ssg_pkg::ROOT_W-1:0]  root_r   [0:N-1];
  ssg_pkg::ssg_side_t          side_r   [0:N-1];
  logic [47:0]                 rad_in   [0:N-1];
  logic [26:0]                 rem_in   [0:N-1];
  logic [ssg_pkg::ROOT_W-1:0]  root_in  [0:N-1];
  ssg_pkg::ssg_side_t          side_in  [0:N-1];
  logic [26:0]                 rem_nxt  [0:N-1];
  logic [ssg_pkg::ROOT_W-1:0]  root_nxt [0:N-1];

  always_comb begin
    rad_in[0] = {1'b0, up_rad};
    rem_in[0] = '0;
    root_in[0] = '0;
    side_in[0] = up_side;
    for (int k = 1; k < N; k++) begin
      rad_in[k] = rad_r[k-1];
      rem_in[k] = rem_r[k-1];
      root_in[k] = root_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  // Each step brings down the next two radicand bits and tries 4*root + 1.
  always_comb begin
    logic [26:0]                rem;
    logic [ssg_pkg::ROOT_W-1:0] root;
    logic [26:0]                trial;
    for (int k = 0; k < N; k++) begin
      rem = rem_in[k];
      root = root_in[k];
      for (int j = 0; j < STEPS; j++) begin
        rem = {rem[24:0], rad_in[k][2 * (23 - STEPS * k - j) +: 2]};
        trial = {1'b0, root, 2'b01};
        if (rem >= trial) begin
          rem = rem - trial;
          root = {root[22:0], 1'b1};
        end else begin
          root = {root[22:0], 1'b0};
        end
      end
      rem_nxt[k] = rem;
      root_nxt[k] = root;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        rad_r[k] <= rad_in[k];
        rem_r[k] <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign dn_side = side_r[N-1];
  assign dn_root = root_r[N-1];

endmodule

`default_nettype wire

// File: sv/ssg_recip.sv
// ----------------------------------------------------------------------------
// Half-width divider
// Computes h = floor(2^33 / (5 * root)) by restoring division, five quotient
// bits per stage after one stage that forms the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_recip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_stall,
  input  wire ssg_pkg::ssg_side_t            up_side,
  input  wire logic [ssg_pkg::ROOT_W-1:0]    up_root,
  output logic                               dn_valid,
  input  wire logic                          dn_stall,
  output ssg_pkg::ssg_side_t                 dn_side,
  output logic [ssg_pkg::H_W-1:0]            dn_h
);

  localparam int N = 4;
  localparam int STEPS = 5;
  // The quotient fits in 15 bits, so the division starts at 2^33 >> 15.
  localparam logic [27:0] REM_INIT = 28'h0040000;

  logic [N-1:0] v_r;
  logic [N-1:0] hold;
  logic [N-1:0] en;
  logic [N-1:0] vin;

  for (genvar k = 0; k < N; k++) begin : g_flow
    if (k == N - 1) begin : g_last
      assign hold[k] = dn_stall;
    end else begin : g_mid
      assign hold[k] = v_r[k+1] & hold[k+1];
    end
    assign en[k] = ~v_r[k] | ~hold[k];
  end

  assign vin = {v_r[N-2:0], up_valid};
  assign up_stall = v_r[0] & hold[0];
  assign dn_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  logic [26:0]                den_r    [0:N-1];
  logic [27:0]                rem_r    [0:N-1];
  logic [ssg_pkg::H_W-1:0]    quo_r    [0:N-1];
  ssg_pkg::ssg_side_t         side_r   [0:N-1];
  logic [26:0]                den_nxt  [0:N-1];
  logic [27:0]                rem_nxt  [0:N-1];
  logic [ssg_pkg::H_W-1:0]    quo_nxt  [0:N-1];
  ssg_pkg::ssg_side_t         side_nxt [0:N-1];

  always_comb begin
    logic [27:0]             rem;
    logic [ssg_pkg::H_W-1:0] quo;
    den_nxt[0] = {1'b0, up_root, 2'b00} + 27'(up_root);
    rem_nxt[0] = REM_INIT;
    quo_nxt[0] = '0;
    side_nxt[0] = up_side;
    for (int k = 1; k < N; k++) begin
      rem = rem_r[k-1];
      quo = quo_r[k-1];
      for (int j = 0; j < STEPS; j++) begin
        rem = {rem[26:0], 1'b0};
        if (rem >= {1'b0, den_r[k-1]}) begin
          rem = rem - {1'b0, den_r[k-1]};
          quo = {quo[ssg_pkg::H_W-2:0], 1'b1};
        end else begin
          quo = {quo[ssg_pkg::H_W-2:0], 1'b0};
        end
      end
      den_nxt[k] = den_r[k-1];
      rem_nxt[k] = rem;
      quo_nxt[k] = quo;
      side_nxt[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) begin
        den_r[k] <= den_nxt[k];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign dn_side = side_r[N-1];
  assign dn_h = quo_r[N-1];

endmodule

`default_nettype wire

// File: sv/ssg_map.sv
// ----------------------------------------------------------------------------
// Screen mapping
// Forms the y offset, the four endpoint coordinates and their pixel values,
// dividing by the extents through a reciprocal table, and saturates them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_map #(
  parameter int HALF_SCREEN_WIDTH  = 159,
  parameter int HALF_SCREEN_HEIGHT = 119
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          up_valid,
  output logic                               up_stall,
  input  wire ssg_pkg::ssg_side_t            up_side,
  input  wire logic [ssg_pkg::H_W-1:0]       up_h,
  input  wire logic [6:0]                    x_ext,
  input  wire logic [6:0]                    y_ext,
  output logic                               dn_valid,
  input  wire logic                          dn_stall,
  output logic                               dn_segment_valid,
  output logic signed [ssg_pkg::PIX_W-1:0]   dn_start_x,
  output logic signed [ssg_pkg::PIX_W-1:0]   dn_start_y,
  output logic signed [ssg_pkg::PIX_W-1:0]   dn_end_x,
  output logic signed [ssg_pkg::PIX_W-1:0]   dn_end_y,
  output logic [2:0]                         dn_color_band
);

  localparam int N = 4;
  localparam int MAXH = (HALF_SCREEN_WIDTH > HALF_SCREEN_HEIGHT) ?
                        HALF_SCREEN_WIDTH : HALF_SCREEN_HEIGHT;
  localparam int CW = $clog2(MAXH + 1);
  localparam int PW = 26 + CW;
  localparam int AW = PW - 16;
  localparam int K = AW + 7;
  localparam int MW = K + 1;
  localparam int QW = AW + 1;
  localparam logic signed [PW-1:0] HSW_W = PW'(HALF_SCREEN_WIDTH);
  localparam logic signed [PW-1:0] HSH_W = PW'(HALF_SCREEN_HEIGHT);
  localparam logic [QW-1:0] PIX_LIMIT = QW'(ssg_pkg::PIX_MAX);

  logic [N-1:0] v_r;
  logic [N-1:0] hold;
  logic [N-1:0] en;
  logic [N-1:0] vin;

  for (genvar k = 0; k < N; k++) begin : g_flow
    if (k == N - 1) begin : g_last
      assign hold[k] = dn_stall;
    end else begin : g_mid
      assign hold[k] = v_r[k+1] & hold[k+1];
    end
    assign en[k] = ~v_r[k] | ~hold[k];
  end

  assign vin = {v_r[N-2:0], up_valid};
  assign up_stall = v_r[0] & hold[0];
  assign dn_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (en[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  // ceil(2^K / e); a zero extent register reads as one.
  logic [MW-1:0] ext_tab [0:127];

  for (genvar g = 0; g < 128; g++) begin : g_ext
    localparam int GE = (g == 0) ? 1 : g;
    localparam logic [MW-1:0] RV = MW'((2 ** K + GE - 1) / GE);
    assign ext_tab[g] = RV;
  end

  logic [6:0] ex_eff;
  logic [6:0] ey_eff;

  assign ex_eff = (x_ext == 7'd0) ? 7'd1 : x_ext;
  assign ey_eff = (y_ext == 7'd0) ? 7'd1 : y_ext;

  // Stage 0: y offset d = trunc(slope * h / 2^16).
  logic signed [39:0]          dprod;
  logic signed [15:0]          d_nxt;
  logic signed [15:0]          d_r;
  logic [ssg_pkg::H_W-1:0]     h_r;
  ssg_pkg::ssg_side_t          side0_r;

  always_comb begin
    dprod = 40'(up_side.slope) * $signed({25'b0, up_h});
    if (dprod[39]) begin
      d_nxt = 16'((dprod + 40'sd65535) >>> 16);
    end else begin
      d_nxt = 16'(dprod >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r <= d_nxt;
      h_r <= up_h;
      side0_r <= up_side;
    end
  end

  // Stage 1: offsets from the screen edge in Q.16, scaled by the half screen.
  // Order of the four lanes: start x, start y, end x, end y.
  logic signed [9:0]    sx;
  logic signed [9:0]    sy;
  logic signed [25:0]   base_x;
  logic signed [25:0]   base_y;
  logic signed [25:0]   hx;
  logic signed [25:0]   dx;
  logic signed [25:0]   t     [0:3];
  logic signed [PW-1:0] p_nxt [0:3];
  logic signed [PW-1:0] p_r   [0:3];
  ssg_pkg::ssg_side_t   side1_r;

  always_comb begin
    sx = 10'(side0_r.gx) + $signed({3'b000, ex_eff});
    sy = $signed({3'b000, ey_eff}) - 10'(side0_r.gy);
    base_x = {sx, 16'h0000};
    base_y = {sy, 16'h0000};
    hx = $signed({11'b0, h_r});
    dx = 26'(d_r);
    t[0] = base_x - hx;
    t[1] = base_y + dx;
    t[2] = base_x + hx;
    t[3] = base_y - dx;
    for (int i = 0; i < 4; i++) begin
      if (i % 2 == 0) begin
        p_nxt[i] = PW'(t[i]) * HSW_W;
      end else begin
        p_nxt[i] = PW'(t[i]) * HSH_W;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        p_r[i] <= p_nxt[i];
      end
      side1_r <= side0_r;
    end
  end

  // Stage 2: magnitude / (extent * 2^16) via reciprocal multiply.
  logic [PW-1:0]      absp     [0:3];
  logic [MW-1:0]      rcp      [0:3];
  logic [AW+MW-1:0]   qprod_nxt[0:3];
  logic [AW+MW-1:0]   qprod_r  [0:3];
  logic [3:0]         neg_r;
  ssg_pkg::ssg_side_t side2_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      absp[i] = p_r[i][PW-1] ? PW'(-p_r[i]) : PW'(p_r[i]);
      rcp[i] = (i % 2 == 0) ? ext_tab[x_ext] : ext_tab[y_ext];
      qprod_nxt[i] = (AW+MW)'(absp[i][PW-1:16]) * (AW+MW)'(rcp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 4; i++) begin
        qprod_r[i] <= qprod_nxt[i];
        neg_r[i] <= p_r[i][PW-1];
      end
      side2_r <= side1_r;
    end
  end

  // Stage 3: restore sign, saturate, and blank items with no segment.
  logic [QW-1:0]                  qmag [0:3];
  logic [10:0]                    mag  [0:3];
  logic [ssg_pkg::PIX_W-1:0]      pix_nxt [0:3];
  logic [ssg_pkg::PIX_W-1:0]      pix_r   [0:3];
  logic                           segv_r;
  logic [2:0]                     band_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      qmag[i] = qprod_r[i][AW+MW-1:K];
      mag[i] = (qmag[i] > PIX_LIMIT) ? 11'(ssg_pkg::PIX_MAX) : qmag[i][10:0];
      if (!side2_r.nz) begin
        pix_nxt[i] = '0;
      end else if (neg_r[i]) begin
        pix_nxt[i] = -{1'b0, mag[i]};
      end else begin
        pix_nxt[i] = {1'b0, mag[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) begin
        pix_r[i] <= pix_nxt[i];
      end
      segv_r <= side2_r.nz;
      band_r <= side2_r.nz ? side2_r.band : 3'(ssg_pkg::BAND_RED);
    end
  end

  assign dn_segment_valid = segv_r;
  assign dn_start_x = pix_r[0];
  assign dn_start_y = pix_r[1];
  assign dn_end_x = pix_r[2];
  assign dn_end_y = pix_r[3];
  assign dn_color_band = band_r;

endmodule

`default_nettype wire

// File: verif/ssg_checker.sv
// ----------------------------------------------------------------------------
// Slope segment checker
// Watches the item and result channels of the slope segment generator,
// computes the expected segment of every accepted grid point and compares
// each accepted result with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssg_checker #(
  parameter int HALF_SCREEN_WIDTH  = 159,
  parameter int HALF_SCREEN_HEIGHT = 119
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic signed [7:0] in_grid_x,
  input  logic signed [7:0] in_grid_y,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_segment_valid,
  input  logic [11:0]       out_start_x,
  input  logic [11:0]       out_start_y,
  input  logic [11:0]       out_end_x,
  input  logic [11:0]       out_end_y,
  input  logic [2:0]        out_color_band,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [0:0]        cfg_index,
  input  logic [6:0]        cfg_data,
  output int                fail_count,
  output int                pending_segments
);

  typedef struct packed {
    logic        seg;
    logic [11:0] sx;
    logic [11:0] sy;
    logic [11:0] ex;
    logic [11:0] ey;
    logic [2:0]  band;
  } segment_t;

  segment_t    segment_q[$];
  logic [6:0]  x_ext;
  logic [6:0]  y_ext;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [11:0] clamp_pixel(longint v);
    if (v > ssg_pkg::PIX_MAX) return 12'(ssg_pkg::PIX_MAX);
    if (v < -ssg_pkg::PIX_MAX) return 12'(-ssg_pkg::PIX_MAX);
    return 12'(v);
  endfunction

  function automatic segment_t segment_of(logic signed [7:0] gx8, logic signed [7:0] gy8);
    segment_t        r;
    longint          gx, gy, ex, ey, s, h, d, n, dn, den_x, den_y;
    longint unsigned root;
    gx = gx8;
    gy = gy8;
    ex = (x_ext == 0) ? 1 : x_ext;
    ey = (y_ext == 0) ? 1 : y_ext;
    r = '0;
    if (gx == 0) return r;
    s = (-gy * 65536) / gx;
    if (s > 8388607) s = 8388607;
    if (s < -8388608) s = -8388608;
    root = int_sqrt((64'd1 << 32) + longint'(s * s));
    h = longint'((64'd2 << 32) / (5 * root));
    d = (s * h) / 65536;
    n = -gy;
    dn = gx;
    if (dn < 0) begin
      n = -n;
      dn = -dn;
    end
    if (n >= 2 * dn) r.band = ssg_pkg::BAND_RED;
    else if (n >= dn) r.band = ssg_pkg::BAND_ORANGE;
    else if (n >= 0) r.band = ssg_pkg::BAND_YELLOW;
    else if (n >= -dn) r.band = ssg_pkg::BAND_GREEN;
    else if (n >= -2 * dn) r.band = ssg_pkg::BAND_LIGHT_BLUE;
    else r.band = ssg_pkg::BAND_NAVY;
    den_x = ex * 65536;
    den_y = ey * 65536;
    r.seg = 1'b1;
    r.sx = clamp_pixel(((gx * 65536 - h) * HALF_SCREEN_WIDTH
                        + HALF_SCREEN_WIDTH * den_x) / den_x);
    r.ex = clamp_pixel(((gx * 65536 + h) * HALF_SCREEN_WIDTH
                        + HALF_SCREEN_WIDTH * den_x) / den_x);
    r.sy = clamp_pixel((HALF_SCREEN_HEIGHT * den_y
                        - (gy * 65536 - d) * HALF_SCREEN_HEIGHT) / den_y);
    r.ey = clamp_pixel((HALF_SCREEN_HEIGHT * den_y
                        - (gy * 65536 + d) * HALF_SCREEN_HEIGHT) / den_y);
    return r;
  endfunction

  always @(posedge clk) begin
    segment_t want;
    segment_t got;
    if (!rst_n) begin
      x_ext <= 7'd10;
      y_ext <= 7'd10;
      fail_count <= 0;
      pending_segments <= 0;
      segment_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ssg_pkg::CFG_X_EXTENT) x_ext <= cfg_data;
        else y_ext <= cfg_data;
      end
      if (in_valid && !in_stall) segment_q.push_back(segment_of(in_grid_x, in_grid_y));
      if (out_valid && !out_stall) begin
        got = {out_segment_valid, out_start_x, out_start_y, out_end_x, out_end_y,
               out_color_band};
        if (segment_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", got);
        end else begin
          want = segment_q.pop_front();
          if (want != got) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"mismatch: seg %b/%b sx %0d/%0d sy %0d/%0d ex %0d/%0d",
                        " ey %0d/%0d band %0d/%0d"},
                       want.seg, got.seg, $signed(want.sx), $signed(got.sx),
                       $signed(want.sy), $signed(got.sy), $signed(want.ex),
                       $signed(got.ex), $signed(want.ey), $signed(got.ey),
                       want.band, got.band);
          end
        end
      end
      pending_segments <= segment_q.size();
    end
  end

endmodule

// File: verif/tb_slope_segment_generator_unit.sv
// ----------------------------------------------------------------------------
// Slope segment generator testbench
// Drives directed and random grid points under several extent settings with
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_slope_segment_generator_unit;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [7:0] in_grid_x = '0;
  logic signed [7:0] in_grid_y = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_segment_valid;
  logic [11:0]       out_start_x, out_start_y, out_end_x, out_end_y;
  logic [2:0]        out_color_band;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = ssg_pkg::CFG_X_EXTENT;
  logic [6:0]        cfg_data = '0;
  int                fail_count;
  int                pending_segments;
  int                cycle_count = 0;
  bit                calm = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  slope_segment_generator_unit u_top (.*);

  ssg_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_stall <= !calm && ($urandom_range(99) < 20);
    if (cycle_count > 400000) begin
      $display("tb_slope_segment_generator_unit: FAIL");
      $finish;
    end
  end

  // The item stays valid after it is taken; the next call either idles or
  // presents the next item, so points can follow back to back.
  task automatic send_point(logic signed [7:0] gx, logic signed [7:0] gy);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_grid_x <= gx;
    in_grid_y <= gy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_extent(ssg_pkg::ssg_cfg_idx_t idx, logic [6:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_segments != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_points(int count);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0)
        send_point($urandom_range(1) ? 8'sd127 : -8'sd127, 8'($urandom));
      else
        send_point(8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int m;
    logic [6:0] x_set[5];
    logic [6:0] y_set[5];
    x_set = '{7'd10, 7'd1, 7'd127, 7'd0, 7'd37};
    y_set = '{7'd10, 7'd127, 7'd1, 7'd0, 7'd64};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: extremes, zero x, every color band boundary, steep slopes.
    send_point(0, 0);
    send_point(0, 127);
    send_point(127, 127);
    send_point(-127, -127);
    send_point(-128, -128);
    send_point(127, -128);
    send_point(1, -127);
    send_point(1, 127);
    send_point(-1, 127);
    send_point(1, -2);
    send_point(1, -1);
    send_point(1, 0);
    send_point(1, 1);
    send_point(1, 2);
    send_point(-3, 7);
    send_point(-3, -7);
    send_point(5, 11);
    send_point(-128, 0);
    send_point(-1, -1);
    for (m = 0; m < 5; m++) begin
      write_extent(ssg_pkg::CFG_X_EXTENT, x_set[m]);
      write_extent(ssg_pkg::CFG_Y_EXTENT, y_set[m]);
      calm = (m == 2);
      random_points(100);
    end
    calm = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_segments != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_slope_segment_generator_unit: PASS");
    end else begin
      $display("tb_slope_segment_generator_unit: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/ssg_pkg.sv
sv/ssg_slope.sv
sv/ssg_sqrt.sv
sv/ssg_recip.sv
sv/ssg_map.sv
sv/slope_segment_generator_unit.sv
verif/ssg_checker.sv
verif/tb_slope_segment_generator_unit.sv
